// ----- rtl/cpfb_pkg.sv -----
package cpfb_pkg;

  localparam logic [7:0]  HDR_BYTE  = 8'h55;
  localparam logic [7:0]  END_BYTE  = 8'hAA;
  localparam logic [7:0]  SVC_KIND0 = 8'h01;
  localparam logic [7:0]  SVC_KIND1 = 8'h80;
  localparam logic [8:0]  LEN_BIAS  = 9'd10;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFFFFFF;

  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCountW = $clog2(QDepth + 1);

  localparam int IdxW = 3;

  // Byte positions inside a start or end run
  localparam logic [IdxW-1:0] POS_HDR      = 3'd0;
  localparam logic [IdxW-1:0] POS_RX       = 3'd1;
  localparam logic [IdxW-1:0] POS_TX       = 3'd2;
  localparam logic [IdxW-1:0] POS_LEN_LO   = 3'd3;
  localparam logic [IdxW-1:0] POS_LEN_HI   = 3'd4;
  localparam logic [IdxW-1:0] POS_SVC      = 3'd5;
  localparam logic [IdxW-1:0] POS_CMD      = 3'd6;
  localparam logic [IdxW-1:0] POS_CRC0     = 3'd0;
  localparam logic [IdxW-1:0] POS_CRC1     = 3'd1;
  localparam logic [IdxW-1:0] POS_CRC2     = 3'd2;
  localparam logic [IdxW-1:0] POS_CRC3     = 3'd3;
  localparam logic [IdxW-1:0] POS_END_LAST = 3'd5;

  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 4;

  typedef enum logic [CfgAddrW-1:0] {
    REG_OWN_MODULE  = 2'd0,
    REG_OWN_CHASSIS = 2'd1,
    REG_DEVICE_KIND = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_END   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // One queued job; data holds the command on start, the payload byte on data
  typedef struct packed {
    kind_e      kind;
    logic [7:0] rx;
    logic [7:0] tx;
    logic [7:0] len_lo;
    logic [7:0] len_hi;
    logic [7:0] svc;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_push_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/cpfb_front.sv -----
module cpfb_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      action_i,
  input  logic [3:0]                      receiver_module_i,
  input  logic [3:0]                      receiver_chassis_i,
  input  logic [7:0]                      command_i,
  input  logic [7:0]                      payload_length_i,
  input  logic [7:0]                      payload_byte_i,
  input  logic                            cfg_we_i,
  input  logic [cpfb_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [cpfb_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            q_full_i,
  output cpfb_pkg::q_push_t               push_o
);
  import cpfb_pkg::*;

  logic [3:0] own_module_q, own_module_d;
  logic [3:0] own_chassis_q, own_chassis_d;
  logic       device_kind_q, device_kind_d;
  logic       frame_open_q, frame_open_d;
  logic       accept;
  logic [8:0] len;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign len        = {1'b0, payload_length_i} + LEN_BIAS;

  always_comb begin
    own_module_d  = own_module_q;
    own_chassis_d = own_chassis_q;
    device_kind_d = device_kind_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_OWN_MODULE:  own_module_d  = cfg_wdata_i[3:0];
        REG_OWN_CHASSIS: own_chassis_d = cfg_wdata_i[3:0];
        REG_DEVICE_KIND: device_kind_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    frame_open_d        = frame_open_q;
    push_o.valid        = 1'b0;
    push_o.entry.kind   = KIND_DATA;
    push_o.entry.rx     = {receiver_chassis_i, receiver_module_i};
    push_o.entry.tx     = {own_chassis_q, own_module_q};
    push_o.entry.len_lo = len[7:0];
    push_o.entry.len_hi = {7'd0, len[8]};
    push_o.entry.svc    = device_kind_q ? SVC_KIND1 : SVC_KIND0;
    push_o.entry.data   = payload_byte_i;
    if (accept) begin
      case (action_e'(action_i))
        ACT_START: begin
          push_o.valid      = 1'b1;
          push_o.entry.kind = KIND_START;
          push_o.entry.data = command_i;
          frame_open_d      = 1'b1;
        end
        ACT_DATA: begin
          push_o.valid      = frame_open_q;
          push_o.entry.kind = KIND_DATA;
        end
        ACT_END: begin
          push_o.valid      = frame_open_q;
          push_o.entry.kind = KIND_END;
          frame_open_d      = 1'b0;
        end
        default: ;  // unused action code: beat dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_module_q  <= '0;
      own_chassis_q <= '0;
      device_kind_q <= 1'b0;
      frame_open_q  <= 1'b0;
    end else begin
      own_module_q  <= own_module_d;
      own_chassis_q <= own_chassis_d;
      device_kind_q <= device_kind_d;
      frame_open_q  <= frame_open_d;
    end
  end

endmodule

// ----- rtl/cpfb_queue.sv -----
module cpfb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpfb_pkg::q_push_t push_i,
  output logic              full_o,
  output logic              head_valid_o,
  output cpfb_pkg::entry_t  head_o,
  input  logic              pop_i
);
  import cpfb_pkg::*;

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCountW-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o       = (count_q == QCountW'(QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- rtl/cpfb_back.sv -----
module cpfb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  cpfb_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       frame_byte_o,
  output logic             last_of_run_o,
  output logic             frame_done_o
);
  import cpfb_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     crc_q, crc_d;
  logic [31:0]     crc_fin;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic            done_q, done_d;
  logic            slot_free, step;
  logic [7:0]      cur_byte;
  logic            cur_last, cur_done, cur_upd;

  assign slot_free = !out_valid_q || out_ready_i;
  assign step      = head_valid_i && slot_free;
  assign pop_o     = step && cur_last;
  assign crc_fin   = crc_q ^ CRC_ONES;

  // Byte select for the job at the queue head
  always_comb begin
    cur_byte = head_i.data;
    cur_last = 1'b0;
    cur_done = 1'b0;
    cur_upd  = 1'b0;
    case (head_i.kind)
      KIND_START: begin
        cur_upd  = (idx_q >= POS_TX);
        cur_last = (idx_q == POS_CMD);
        case (idx_q)
          POS_HDR:    cur_byte = HDR_BYTE;
          POS_RX:     cur_byte = head_i.rx;
          POS_TX:     cur_byte = head_i.tx;
          POS_LEN_LO: cur_byte = head_i.len_lo;
          POS_LEN_HI: cur_byte = head_i.len_hi;
          POS_SVC:    cur_byte = head_i.svc;
          default:    cur_byte = head_i.data;
        endcase
      end
      KIND_DATA: begin
        cur_upd  = 1'b1;
        cur_last = 1'b1;
      end
      KIND_END: begin
        cur_last = (idx_q == POS_END_LAST);
        cur_done = cur_last;
        case (idx_q)
          POS_CRC0: cur_byte = crc_fin[7:0];
          POS_CRC1: cur_byte = crc_fin[15:8];
          POS_CRC2: cur_byte = crc_fin[23:16];
          POS_CRC3: cur_byte = crc_fin[31:24];
          default:  cur_byte = END_BYTE;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    last_d      = last_q;
    done_d      = done_q;
    if (step) begin
      idx_d       = cur_last ? '0 : idx_q + 1'b1;
      out_valid_d = 1'b1;
      byte_d      = cur_byte;
      last_d      = cur_last;
      done_d      = cur_done;
      if (head_i.kind == KIND_START && idx_q == POS_HDR) begin
        crc_d = CRC_ONES;
      end else if (cur_upd) begin
        crc_d = crc_byte(crc_q, cur_byte);
      end else if (cur_done) begin
        crc_d = CRC_ONES;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      crc_q       <= CRC_ONES;
      out_valid_q <= 1'b0;
      byte_q      <= '0;
      last_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      byte_q      <= byte_d;
      last_q      <= last_d;
      done_q      <= done_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_byte_o  = byte_q;
  assign last_of_run_o = last_q;
  assign frame_done_o  = done_q;

`ifndef NO_ASSERTIONS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> last_q)
    else $error("frame_done without last_of_run");

  a_data_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i && head_i.kind == KIND_DATA |-> idx_q == '0)
    else $error("data job at nonzero byte position");

  a_pop_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && last_q)
    else $error("pop without final beat in output register");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= POS_CMD)
    else $error("byte position out of range");
`endif

endmodule

// ----- rtl/crc32_packet_frame_builder.sv -----
// Channel  Direction  Handshake                    Beat
// in       input      in_valid_i / in_ready_o      one action with its fields
// out      output     out_valid_o / out_ready_i    one frame byte with flags
// cfg      input      cfg_we_i                     one register write
//
// One output beat per cycle while a job is queued and out_ready_i allows:
// start gives 7 beats, payload 1, end 6. Input beats are taken every cycle
// while the 4-deep job queue has room, so a start is absorbed as one entry
// and the output side stalls alone. Dropped actions use no output beats.
// Reset clears config and the open-frame flag and sets the CRC to all ones.
module crc32_packet_frame_builder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [3:0]                    receiver_module_i,
  input  logic [3:0]                    receiver_chassis_i,
  input  logic [7:0]                    command_i,
  input  logic [7:0]                    payload_length_i,
  input  logic [7:0]                    payload_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    frame_byte_o,
  output logic                          last_of_run_o,
  output logic                          frame_done_o,
  input  logic                          cfg_we_i,
  input  logic [cpfb_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [cpfb_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import cpfb_pkg::*;

  q_push_t push;
  logic    q_full;
  logic    head_valid;
  entry_t  head;
  logic    pop;

  cpfb_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .receiver_module_i  (receiver_module_i),
    .receiver_chassis_i (receiver_chassis_i),
    .command_i          (command_i),
    .payload_length_i   (payload_length_i),
    .payload_byte_i     (payload_byte_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .q_full_i           (q_full),
    .push_o             (push)
  );

  cpfb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  cpfb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_byte_o  (frame_byte_o),
    .last_of_run_o (last_of_run_o),
    .frame_done_o  (frame_done_o)
  );

endmodule

// ----- bench/tb_crc32_packet_frame_builder.sv -----
`timescale 1ns / 100ps

module tb_crc32_packet_frame_builder;
  import cpfb_pkg::*;

  localparam logic [1:0] ACT_RSVD    = 2'd3;
  localparam int         NO_TYPED    = -1;
  localparam int         TAIL_CYCLES = 16;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_ITEMS = 65;
  localparam int         N_PHASES    = 5;
  localparam int         N_ROWS      = 20;

  typedef struct {
    logic [1:0]  action;
    logic [3:0]  rm;
    logic [3:0]  rc;
    logic [7:0]  cmd;
    logic [7:0]  plen;
    logic [7:0]  pbyte;
    int          typed_n;  // results typed in by hand, NO_TYPED to use the predictor
    logic [55:0] hdr;      // typed header, first byte in the top bits
  } stim_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    logic       done;
  } frame_beat_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready_o;
  stim_t cur_item;
  logic out_valid_o;
  logic out_ready;
  logic [7:0] frame_byte_o;
  logic last_of_run_o;
  logic frame_done_o;
  logic cfg_we;
  cfg_reg_e cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  // predictor state and its copy of the registers
  logic [31:0] crc_state;
  logic        frame_is_open;
  logic [3:0]  cfg_module;
  logic [3:0]  cfg_chassis;
  logic        cfg_kind;

  frame_beat_t run_bytes[$];
  frame_beat_t frame_bytes_due[$];

  logic no_gaps;
  int   err_count;
  int   useful_items;
  int   ignored_items;
  int   beats_checked;
  int   frames_closed;
  int   cfg_settings;
  int   cycle_count;

  stim_t directed_rows [N_ROWS] = '{
    '{ACT_DATA,  4'h0, 4'h0, 8'h00, 8'h00, 8'hFF, 0, 56'h0},
    '{ACT_END,   4'hF, 4'hF, 8'hFF, 8'hFF, 8'h00, 0, 56'h0},
    '{ACT_RSVD,  4'h0, 4'h0, 8'h00, 8'h00, 8'h00, 0, 56'h0},
    '{ACT_START, 4'h0, 4'h0, 8'h00, 8'h00, 8'h00, 7, 56'h55_00_00_0A_00_01_00},
    '{ACT_END,   4'h0, 4'h0, 8'h00, 8'h00, 8'h00, NO_TYPED, 56'h0},
    '{ACT_START, 4'hF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 7, 56'h55_FF_00_09_01_01_FF},
    '{ACT_DATA,  4'h0, 4'h0, 8'h00, 8'h00, 8'h00, NO_TYPED, 56'h0},
    '{ACT_DATA,  4'h0, 4'h0, 8'h00, 8'h00, 8'hFF, NO_TYPED, 56'h0},
    '{ACT_DATA,  4'hF, 4'hF, 8'hFF, 8'hFF, 8'hA5, NO_TYPED, 56'h0},
    '{ACT_DATA,  4'h0, 4'h0, 8'h00, 8'h00, 8'h5A, NO_TYPED, 56'h0},
    '{ACT_RSVD,  4'hF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 0, 56'h0},
    // start while open drops the old frame
    '{ACT_START, 4'h5, 4'hA, 8'h3C, 8'h02, 8'h00, 7, 56'h55_A5_00_0C_00_01_3C},
    '{ACT_DATA,  4'h0, 4'h0, 8'h00, 8'h00, 8'h11, NO_TYPED, 56'h0},
    '{ACT_DATA,  4'h0, 4'h0, 8'h00, 8'h00, 8'h22, NO_TYPED, 56'h0},
    '{ACT_END,   4'h0, 4'h0, 8'h00, 8'h00, 8'h00, NO_TYPED, 56'h0},
    '{ACT_END,   4'h0, 4'h0, 8'h00, 8'h00, 8'h00, 0, 56'h0},
    '{ACT_DATA,  4'h0, 4'h0, 8'h00, 8'h00, 8'h77, 0, 56'h0},
    '{ACT_START, 4'h3, 4'hC, 8'h81, 8'h01, 8'h00, 7, 56'h55_C3_00_0B_00_01_81},
    '{ACT_DATA,  4'h0, 4'h0, 8'h00, 8'h00, 8'h80, NO_TYPED, 56'h0},
    '{ACT_END,   4'h0, 4'h0, 8'h00, 8'h00, 8'h00, NO_TYPED, 56'h0}
  };

  crc32_packet_frame_builder dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .action_i           (cur_item.action),
    .receiver_module_i  (cur_item.rm),
    .receiver_chassis_i (cur_item.rc),
    .command_i          (cur_item.cmd),
    .payload_length_i   (cur_item.plen),
    .payload_byte_i     (cur_item.pbyte),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .frame_byte_o       (frame_byte_o),
    .last_of_run_o      (last_of_run_o),
    .frame_done_o       (frame_done_o),
    .cfg_we_i           (cfg_we),
    .cfg_addr_i         (cfg_addr),
    .cfg_wdata_i        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // bit-serial reflected CRC-32 update
  function automatic logic [31:0] crc32_feed(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ d[i]) ? CRC_POLY : 32'h0);
    end
    return r;
  endfunction

  task automatic frame_model_step(input stim_t it);
    logic [7:0]  hb [7];
    logic [15:0] frame_len;
    logic [31:0] fin;
    case (it.action)
      ACT_START: begin
        frame_len = 16'(LEN_BIAS) + 16'(it.plen);
        hb[0] = HDR_BYTE;
        hb[1] = {it.rc, it.rm};
        hb[2] = {cfg_chassis, cfg_module};
        hb[3] = frame_len[7:0];
        hb[4] = frame_len[15:8];
        hb[5] = cfg_kind ? SVC_KIND1 : SVC_KIND0;
        hb[6] = it.cmd;
        crc_state = CRC_ONES;
        for (int k = 2; k < 7; k++) crc_state = crc32_feed(crc_state, hb[k]);
        for (int k = 0; k < 7; k++) run_bytes.push_back('{hb[k], k == 6, 1'b0});
        frame_is_open = 1'b1;
      end
      ACT_DATA: begin
        if (frame_is_open) begin
          crc_state = crc32_feed(crc_state, it.pbyte);
          run_bytes.push_back('{it.pbyte, 1'b1, 1'b0});
        end
      end
      ACT_END: begin
        if (frame_is_open) begin
          fin = crc_state ^ CRC_ONES;
          for (int k = 0; k < 4; k++) run_bytes.push_back('{fin[8*k +: 8], 1'b0, 1'b0});
          run_bytes.push_back('{END_BYTE, 1'b0, 1'b0});
          run_bytes.push_back('{END_BYTE, 1'b1, 1'b1});
          crc_state = CRC_ONES;
          frame_is_open = 1'b0;
        end
      end
      default: ;  // reserved action leaves everything alone
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic take_item(input stim_t it);
    run_bytes.delete();
    frame_model_step(it);
    if (it.typed_n != NO_TYPED) begin
      run_bytes.delete();
      for (int k = 0; k < it.typed_n; k++)
        run_bytes.push_back('{it.hdr[55 - 8*k -: 8], k == it.typed_n - 1, 1'b0});
    end
    if (run_bytes.size() == 0) ignored_items++;
    else useful_items++;
    foreach (run_bytes[k]) frame_bytes_due.push_back(run_bytes[k]);
  endtask

  task automatic check_beat(input logic [7:0] octet, input logic last, input logic done);
    frame_beat_t want;
    if (frame_bytes_due.size() == 0) begin
      report_mismatch($sformatf("beat %h with nothing pending", octet));
    end else begin
      want = frame_bytes_due.pop_front();
      beats_checked++;
      if (octet !== want.octet)
        report_mismatch($sformatf("frame_byte %h, want %h", octet, want.octet));
      if (last !== want.last)
        report_mismatch($sformatf("last_of_run %b, want %b (byte %h)", last, want.last,
                                  want.octet));
      if (done !== want.done)
        report_mismatch($sformatf("frame_done %b, want %b (byte %h)", done, want.done,
                                  want.octet));
      if (want.done) frames_closed++;
    end
  endtask

  // input take is predicted before the output beat of the same edge is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) take_item(cur_item);
      if (out_valid_o && out_ready) check_beat(frame_byte_o, last_of_run_o, frame_done_o);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_count,
               frame_bytes_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall before each beat
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid_o);
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at the falling edge after the take
  task automatic send_item(input stim_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready_o);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk);
    // idle tail before the next step
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [3:0] mod, input logic [3:0] chs, input logic kind);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_OWN_MODULE;
    cfg_wdata <= mod;
    cfg_module = mod;
    @(negedge clk);
    cfg_addr  <= REG_OWN_CHASSIS;
    cfg_wdata <= chs;
    cfg_chassis = chs;
    @(negedge clk);
    cfg_addr  <= REG_DEVICE_KIND;
    cfg_wdata <= {3'b000, kind};
    cfg_kind = kind;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_settings++;
    @(negedge clk);
  endtask

  function automatic stim_t rand_item();
    stim_t it;
    it.action  = 2'($urandom_range(0, 3));
    it.rm      = 4'($urandom);
    it.rc      = 4'($urandom);
    it.cmd     = 8'($urandom);
    it.plen    = 8'($urandom);
    it.pbyte   = 8'($urandom);
    it.typed_n = NO_TYPED;
    it.hdr     = '0;
    return it;
  endfunction

  task automatic send_random_frame();
    stim_t it;
    int n_bytes;
    it = rand_item();
    it.action = ACT_START;
    if ($urandom_range(0, 7) != 0) it.plen = 8'($urandom_range(0, 10));
    send_item(it);
    // the block does not count payload, so the count may disagree
    if ($urandom_range(0, 4) == 0) n_bytes = $urandom_range(0, 10);
    else n_bytes = (it.plen > 10) ? 10 : int'(it.plen);
    repeat (n_bytes) begin
      it = rand_item();
      it.action = ACT_DATA;
      send_item(it);
    end
    if ($urandom_range(0, 9) != 0) begin
      it = rand_item();
      it.action = ACT_END;
      send_item(it);
    end
  endtask

  initial begin
    int phase_goal;
    logic [3:0] ph_mod [N_PHASES];
    logic [3:0] ph_chs [N_PHASES];
    logic       ph_kind [N_PHASES];
    ph_mod  = '{4'hF, 4'h0, 4'hF, 4'($urandom), 4'h5};
    ph_chs  = '{4'hF, 4'hF, 4'h0, 4'($urandom), 4'hA};
    ph_kind = '{1'b1, 1'b0, 1'b1, 1'($urandom), 1'b0};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    cur_item      = '{2'd0, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0, NO_TYPED, 56'd0};
    cfg_we        = 1'b0;
    cfg_addr      = REG_OWN_MODULE;
    cfg_wdata     = '0;
    crc_state     = CRC_ONES;
    frame_is_open = 1'b0;
    cfg_module    = 4'd0;
    cfg_chassis   = 4'd0;
    cfg_kind      = 1'b0;
    no_gaps       = 1'b0;
    err_count     = 0;
    useful_items  = 0;
    ignored_items = 0;
    beats_checked = 0;
    frames_closed = 0;
    cfg_settings  = 0;
    cycle_count   = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // typed headers below assume sender 0x00 and service 0x01
    set_config(4'h0, 4'h0, 1'b0);
    for (int i = 0; i < N_ROWS; i++) send_item(directed_rows[i]);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      set_config(ph_mod[p], ph_chs[p], ph_kind[p]);
      no_gaps = (p == 1);  // one phase at full rate on both sides
      phase_goal = useful_items + PHASE_ITEMS;
      while (useful_items < phase_goal) begin
        if (p != 1 && $urandom_range(0, 19) == 0) no_gaps = !no_gaps;
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 2)) send_item(rand_item());
        end else begin
          send_random_frame();
        end
        if ($urandom_range(0, 39) == 0) drain();
      end
      no_gaps = 1'b0;
      drain();
    end

    $display("run covered %0d frames closed, %0d items with output, %0d ignored items",
             frames_closed, useful_items, ignored_items);
    $display("%0d beats checked over %0d register settings, %0d mismatches",
             beats_checked, cfg_settings, err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
